### rtl/core/imm_pkg.sv
package imm_pkg;

    // Field widths
    localparam int IDX_W   = 2;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = 34;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int OP_W      = 2;

    // Operation codes carried on tuser
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic                     wr_a;
        logic                     wr_b;
        logic [IDX_W-1:0]         wr_row;
        logic [IDX_W-1:0]         wr_col;
        logic signed [ELEM_W-1:0] wr_data;
        logic                     mul_en;
        logic                     mul_first;
        logic [IDX_W-1:0]         rd_i;
        logic [IDX_W-1:0]         rd_j;
        logic [IDX_W-1:0]         rd_k;
    } t_dp_cmd;

endpackage

### rtl/core/imm_datapath.sv
module imm_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  imm_pkg::t_dp_cmd                 i_cmd,
    output logic signed [imm_pkg::ACC_W-1:0] o_acc
);
    import imm_pkg::*;

    logic signed [ELEM_W-1:0] r_store_a [DEPTH];
    logic signed [ELEM_W-1:0] r_store_b [DEPTH];
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_first;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    // Element stores, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < DEPTH; n++) begin
                r_store_a[n] <= '0;
                r_store_b[n] <= '0;
            end
        end else begin
            if (i_cmd.wr_a) begin
                r_store_a[{i_cmd.wr_row, i_cmd.wr_col}] <= i_cmd.wr_data;
            end
            if (i_cmd.wr_b) begin
                r_store_b[{i_cmd.wr_row, i_cmd.wr_col}] <= i_cmd.wr_data;
            end
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld   <= 1'b0;
            r_prod_first <= 1'b0;
        end else begin
            r_prod_vld   <= i_cmd.mul_en;
            r_prod_first <= i_cmd.mul_first;
        end
    end

    // Operand fetch A[i][k] and B[k][j], multiplied as they are read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(r_store_a[{i_cmd.rd_i, i_cmd.rd_k}])
                    * PROD_W'(r_store_b[{i_cmd.rd_k, i_cmd.rd_j}]);
        end
    end

    // Accumulate stage; first product of an element restarts the sum
    always_comb begin
        n_acc = r_acc;
        if (r_prod_vld) begin
            n_acc = (r_prod_first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

### rtl/core/imm_ctrl.sv
module imm_ctrl #(
    parameter int ROWS_A = 4,
    parameter int INNER  = 4,
    parameter int COLS_B = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [imm_pkg::OP_W-1:0]      i_op,
    input  logic [imm_pkg::IDX_W-1:0]     i_row,
    input  logic [imm_pkg::IDX_W-1:0]     i_col,
    input  logic [imm_pkg::ELEM_W-1:0]    i_elem,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [imm_pkg::IDX_W-1:0]     o_out_row,
    output logic [imm_pkg::IDX_W-1:0]     o_out_col,
    output logic                          o_out_last,
    output imm_pkg::t_dp_cmd              o_cmd
);
    import imm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [IDX_W-1:0] I_LAST = IDX_W'(ROWS_A - 1);
    localparam logic [IDX_W-1:0] J_LAST = IDX_W'(COLS_B - 1);
    localparam logic [IDX_W-1:0] K_LAST = IDX_W'(INNER - 1);

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] n_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] n_j;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] n_k;
    logic             w_accept;
    logic             w_a_in;
    logic             w_b_in;
    logic             w_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Load bounds: A is ROWS_A x INNER, B is INNER x COLS_B
    assign w_a_in = ({1'b0, i_row} < (IDX_W+1)'(ROWS_A))
                 && ({1'b0, i_col} < (IDX_W+1)'(INNER));
    assign w_b_in = ({1'b0, i_row} < (IDX_W+1)'(INNER))
                 && ({1'b0, i_col} < (IDX_W+1)'(COLS_B));

    assign w_last = (r_i == I_LAST) && (r_j == J_LAST);

    // Next state and index walk
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_op == OP_RUN) begin
                    n_state = ST_MAC;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            ST_MAC: begin
                if (r_k == K_LAST) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_k = '0;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_MAC;
                        if (r_j == J_LAST) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Datapath commands
    always_comb begin
        o_cmd.wr_a      = w_accept && (i_op == OP_LOAD_A) && w_a_in;
        o_cmd.wr_b      = w_accept && (i_op == OP_LOAD_B) && w_b_in;
        o_cmd.wr_row    = i_row;
        o_cmd.wr_col    = i_col;
        o_cmd.wr_data   = i_elem;
        o_cmd.mul_en    = (r_state == ST_MAC);
        o_cmd.mul_first = (r_k == '0);
        o_cmd.rd_i      = r_i;
        o_cmd.rd_j      = r_j;
        o_cmd.rd_k      = r_k;
    end

    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_row   = r_i;
    assign o_out_col   = r_j;
    assign o_out_last  = w_last;

endmodule

### rtl/core/integer_matrix_multiply.sv
// Operation: a load item writes its element and gives no result. A run walks each
// product element through a multiply-accumulate walk over the inner dimension, one
// pipeline drain and one output state that holds until the result is taken; no input
// is accepted until the run has given its last result. One item at a time.
// Reset: synchronous, active low; both element stores are cleared to zero.
module integer_matrix_multiply #(
    parameter int ROWS_A = 4,
    parameter int INNER  = 4,
    parameter int COLS_B = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // row_index[1:0], col_index[3:2], element[19:4], zero pad [23:20]
    input  logic [imm_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // op[1:0]
    input  logic [imm_pkg::OP_W-1:0]          i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_row[1:0], out_col[3:2], product[37:4], zero pad [39:38]
    output logic [imm_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);
    import imm_pkg::*;

    t_dp_cmd                 w_cmd;
    logic signed [ACC_W-1:0] w_acc;
    logic [IDX_W-1:0]        w_out_row;
    logic [IDX_W-1:0]        w_out_col;

    // Sequencer
    imm_ctrl #(
        .ROWS_A (ROWS_A),
        .INNER  (INNER),
        .COLS_B (COLS_B)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_row       (i_s_axis_tdata[IDX_W-1:0]),
        .i_col       (i_s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_elem      (i_s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_row   (w_out_row),
        .o_out_col   (w_out_col),
        .o_out_last  (o_m_axis_tlast),
        .o_cmd       (w_cmd)
    );

    // Stores and multiply-accumulate
    imm_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_acc   (w_acc)
    );

    // Result packing
    assign o_m_axis_tdata = {
        {(M_TDATA_W - ACC_W - 2*IDX_W){1'b0}},
        w_acc,
        w_out_col,
        w_out_row
    };

endmodule
